// ===== rtl/core/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg: shared types and constants
// Field widths, digit constants and the job record that passes from the
// front queue to the conversion back end.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int COLOR_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int TOTAL_W    = 5;
    localparam int MAX_DIGITS = 20;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
    localparam logic [3:0]        BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0]        BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COLOR_W-1:0] color;
        logic               is_zero;
    } t_job;

endpackage

// ===== rtl/core/b2d_if.sv =====
// ----------------------------------------------------------------------------
// b2d_if: channel interfaces
// Valid/ready channels for the value input and the digit output.
// ----------------------------------------------------------------------------
interface b2d_in_if;
    import b2d_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [COLOR_W-1:0] color;

    modport source (output valid, value, color, input ready);
    modport sink   (input valid, value, color, output ready);
endinterface

interface b2d_out_if;
    import b2d_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic [COLOR_W-1:0] digit_color;
    logic [TOTAL_W-1:0] digit_total;
    logic               last_digit;

    modport source (output valid, digit_char, digit_color, digit_total, last_digit,
                    input ready);
    modport sink   (input valid, digit_char, digit_color, digit_total, last_digit,
                    output ready);
endinterface

// ===== rtl/core/b2d_front.sv =====
// ----------------------------------------------------------------------------
// b2d_front: input queue
// Accepts value transactions, flags zero values, and buffers them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module b2d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b2d_in_if.sink        i_in,
    output logic          o_job_valid,
    output b2d_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import b2d_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;
    t_job             in_job;

    assign i_in.ready  = (r_count != (PTR_W+1)'(DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_queue[r_rd_ptr];
    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        in_job.value   = i_in.value;
        in_job.color   = i_in.color;
        in_job.is_zero = (i_in.value == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (PTR_W+1)'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && o_job.is_zero |-> o_job.value == '0)
        else $error("zero flag on nonzero value");

endmodule

// ===== rtl/core/b2d_back.sv =====
// ----------------------------------------------------------------------------
// b2d_back: conversion and digit emit
// Bit-serial shift-add-3 BCD conversion, digit count, then one digit per
// cycle unless stalled, most significant first, through an output register.
// ----------------------------------------------------------------------------
module b2d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  b2d_pkg::t_job i_job,
    output logic          o_job_ready,
    b2d_out_if.source     o_out
);
    import b2d_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]         r_state,     n_state;
    logic [VALUE_W-1:0] r_bin,       n_bin;
    logic [BCD_W-1:0]   r_bcd,       n_bcd;
    logic [COLOR_W-1:0] r_color,     n_color;
    logic [STEP_W-1:0]  r_step,      n_step;
    logic [TOTAL_W-1:0] r_total,     n_total;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char,  n_out_char;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_last,  n_out_last;

    logic [BCD_W-1:0]   bcd_adj;
    logic [TOTAL_W-1:0] total_calc;
    logic [3:0]         cur_digit;
    logic               out_free;

    assign o_job_ready       = (r_state == ST_IDLE);
    assign out_free          = !r_out_valid || o_out.ready;
    assign cur_digit         = r_bcd[4*r_idx +: 4];
    assign o_out.valid       = r_out_valid;
    assign o_out.digit_char  = r_out_char;
    assign o_out.digit_color = r_out_color;
    assign o_out.digit_total = r_out_total;
    assign o_out.last_digit  = r_out_last;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + BCD_ADJ;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // highest nonzero digit sets the count; zero still counts as one digit
    always_comb begin
        total_calc = TOTAL_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                total_calc = TOTAL_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_color     = r_color;
        n_step      = r_step;
        n_total     = r_total;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_color = r_out_color;
        n_out_total = r_out_total;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_bin   = i_job.value;
                    n_color = i_job.color;
                    n_bcd   = '0;
                    n_step  = '0;
                    if (i_job.is_zero) begin
                        n_total = TOTAL_W'(1);
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bin  = r_bin << 1;
                n_bcd  = {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_total = total_calc;
                n_idx   = IDX_W'(total_calc - 1'b1);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ASCII_ZERO + CHAR_W'(cur_digit);
                    n_out_color = r_color;
                    n_out_total = r_total;
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_color     <= n_color;
        r_total     <= n_total;
        r_idx       <= n_idx;
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
    end

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char >= ASCII_ZERO && r_out_char <= ASCII_NINE))
        else $error("digit character out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_total == TOTAL_W'(1) |-> r_out_last)
        else $error("single-digit run without last flag");

    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> TOTAL_W'(r_idx) < r_total)
        else $error("digit index beyond digit count");

    a_count_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COUNT |-> $past(r_state) == ST_CONV)
        else $error("count step not preceded by conversion");

endmodule

// ===== rtl/core/binary_to_decimal_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_digits: binary to decimal ASCII digit converter
// Turns a 64-bit unsigned value into a run of ASCII digit transactions.
// ----------------------------------------------------------------------------
// Each value transaction yields one output transaction per decimal digit,
// most significant first, each carrying the ASCII digit, the input color,
// the total digit count (1 to 20) and a last flag on the final digit. The
// back end takes a value from the queue, converts it in the bit-serial
// shift-add-3 converter, counts the digits, then emits one digit per cycle
// while the output is not stalled; a zero value skips conversion and count.
// The converter handles one value at a time; a two-entry input queue keeps
// accepting values while it works, until the queue is full.
module binary_to_decimal_digits (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2d_in_if.sink    i_in,
    b2d_out_if.source o_out
);
    import b2d_pkg::*;

    logic job_valid;
    logic job_ready;
    t_job job;

    b2d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    b2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_out       (o_out)
    );

endmodule
